/* rtl/core/rpss_pkg.sv */
`timescale 1ns / 1ps

package rpss_pkg;

    // Default sizing handed to the top level
    localparam int DEF_MAX_READ_LENGTH = 1024;
    localparam int DEF_WINDOW_MAX      = 16;

    // Fixed field widths
    localparam int BASE_W     = 8;
    localparam int LEN_W      = 11;
    localparam int RATE_W     = 8;
    localparam int WLEN_W     = 5;
    localparam int SPLIT_W    = 10;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [LEN_W-1:0]  RST_SEED_LENGTH       = 11'd3;
    localparam logic [LEN_W-1:0]  RST_FIRST_MIN_LENGTH  = 11'd3;
    localparam logic [LEN_W-1:0]  RST_SECOND_MIN_LENGTH = 11'd3;
    localparam logic [LEN_W-1:0]  RST_RUN_LIMIT         = 11'd3;
    localparam logic [RATE_W-1:0] RST_FIRST_RATE_ROOF   = 8'd128;
    localparam logic [RATE_W-1:0] RST_SECOND_RATE_FLOOR = 8'd51;
    localparam logic [WLEN_W-1:0] RST_WINDOW_LENGTH     = 5'd4;
    localparam logic [RATE_W-1:0] RST_WINDOW_RATE_LIMIT = 8'd51;

    typedef enum logic [1:0] {
        STATUS_SPLIT    = 2'd0,
        STATUS_NO_SPLIT = 2'd1,
        STATUS_REJECTED = 2'd2
    } scan_status_t;

    typedef enum logic [2:0] {
        REG_SEED_LENGTH            = 3'd0,
        REG_FIRST_PART_MIN_LENGTH  = 3'd1,
        REG_SECOND_PART_MIN_LENGTH = 3'd2,
        REG_MISMATCH_RUN_LIMIT     = 3'd3,
        REG_FIRST_RATE_ROOF        = 3'd4,
        REG_SECOND_RATE_FLOOR      = 3'd5,
        REG_WINDOW_LENGTH          = 3'd6,
        REG_WINDOW_RATE_LIMIT      = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [BASE_W-1:0] read_base;
        logic [BASE_W-1:0] ref_base;
        logic              first_of_read;
        logic              last_of_read;
    } base_word_t;

    typedef struct packed {
        scan_status_t       scan_status;
        logic [SPLIT_W-1:0] split_position;
    } result_word_t;

    typedef struct packed {
        logic [LEN_W-1:0]  seed_length;
        logic [LEN_W-1:0]  first_part_min_length;
        logic [LEN_W-1:0]  second_part_min_length;
        logic [LEN_W-1:0]  mismatch_run_limit;
        logic [RATE_W-1:0] first_rate_roof;
        logic [RATE_W-1:0] second_rate_floor;
        logic [WLEN_W-1:0] window_length;
        logic [RATE_W-1:0] window_rate_limit;
    } cfg_t;

endpackage

/* rtl/core/rpss_cfg.sv */
`timescale 1ns / 1ps

module rpss_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rpss_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [rpss_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [rpss_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output rpss_pkg::cfg_t                   cfg
);
    import rpss_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    cfg_index_t reg_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign reg_index = cfg_index_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                REG_SEED_LENGTH:            cfg_next.seed_length = pwdata[LEN_W-1:0];
                REG_FIRST_PART_MIN_LENGTH:  cfg_next.first_part_min_length = pwdata[LEN_W-1:0];
                REG_SECOND_PART_MIN_LENGTH: cfg_next.second_part_min_length = pwdata[LEN_W-1:0];
                REG_MISMATCH_RUN_LIMIT:     cfg_next.mismatch_run_limit = pwdata[LEN_W-1:0];
                REG_FIRST_RATE_ROOF:        cfg_next.first_rate_roof = pwdata[RATE_W-1:0];
                REG_SECOND_RATE_FLOOR:      cfg_next.second_rate_floor = pwdata[RATE_W-1:0];
                REG_WINDOW_LENGTH:          cfg_next.window_length = pwdata[WLEN_W-1:0];
                REG_WINDOW_RATE_LIMIT:      cfg_next.window_rate_limit = pwdata[RATE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seed_length            <= RST_SEED_LENGTH;
            cfg_reg.first_part_min_length  <= RST_FIRST_MIN_LENGTH;
            cfg_reg.second_part_min_length <= RST_SECOND_MIN_LENGTH;
            cfg_reg.mismatch_run_limit     <= RST_RUN_LIMIT;
            cfg_reg.first_rate_roof        <= RST_FIRST_RATE_ROOF;
            cfg_reg.second_rate_floor      <= RST_SECOND_RATE_FLOOR;
            cfg_reg.window_length          <= RST_WINDOW_LENGTH;
            cfg_reg.window_rate_limit      <= RST_WINDOW_RATE_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            REG_SEED_LENGTH:            prdata = CFG_DATA_W'(cfg_reg.seed_length);
            REG_FIRST_PART_MIN_LENGTH:  prdata = CFG_DATA_W'(cfg_reg.first_part_min_length);
            REG_SECOND_PART_MIN_LENGTH: prdata = CFG_DATA_W'(cfg_reg.second_part_min_length);
            REG_MISMATCH_RUN_LIMIT:     prdata = CFG_DATA_W'(cfg_reg.mismatch_run_limit);
            REG_FIRST_RATE_ROOF:        prdata = CFG_DATA_W'(cfg_reg.first_rate_roof);
            REG_SECOND_RATE_FLOOR:      prdata = CFG_DATA_W'(cfg_reg.second_rate_floor);
            REG_WINDOW_LENGTH:          prdata = CFG_DATA_W'(cfg_reg.window_length);
            REG_WINDOW_RATE_LIMIT:      prdata = CFG_DATA_W'(cfg_reg.window_rate_limit);
        endcase
    end

endmodule

/* rtl/core/rpss_scan.sv */
`timescale 1ns / 1ps

module rpss_scan #(
    parameter int MAX_READ_LENGTH = rpss_pkg::DEF_MAX_READ_LENGTH,
    parameter int WINDOW_MAX      = rpss_pkg::DEF_WINDOW_MAX
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rpss_pkg::cfg_t         cfg,
    input  logic                   fire,
    input  rpss_pkg::base_word_t   word,
    output rpss_pkg::result_word_t result
);
    import rpss_pkg::*;

    localparam int NW     = $clog2(MAX_READ_LENGTH + 1);
    localparam int PW     = $clog2(WINDOW_MAX);
    localparam int LW     = $clog2(WINDOW_MAX + 1);
    localparam int CMPW   = (LW > WLEN_W) ? LW : WLEN_W;
    localparam int SW     = (NW > LEN_W) ? NW : LEN_W;
    localparam int PRODW  = NW + RATE_W;
    localparam int WPRODW = CMPW + RATE_W;

    // Per-read state
    logic [NW-1:0]         idx_reg, idx_next;
    logic                  second_reg, second_next;
    logic                  rej_reg, rej_next;
    logic [NW-1:0]         fl_reg, fl_next;
    logic [NW-1:0]         fm_reg, fm_next;
    logic [NW-1:0]         run_reg, run_next;
    logic [NW-1:0]         sl_reg, sl_next;
    logic [NW-1:0]         sm_reg, sm_next;
    logic [WINDOW_MAX-1:0] flags_reg, flags_next;
    logic [PW-1:0]         ptr_reg, ptr_next;
    logic [NW-1:0]         split_reg, split_next;

    // State as seen by this word (cleared on first base)
    logic [NW-1:0]         cur_idx, cur_fl, cur_fm, cur_run, cur_sl, cur_sm, cur_split;
    logic                  cur_second, cur_rej;
    logic [WINDOW_MAX-1:0] cur_flags;
    logic [PW-1:0]         cur_ptr;

    logic [CMPW-1:0]       wl_ext, eff_len;
    logic [WINDOW_MAX-1:0] win_mask, flags_wr;
    logic [PW-1:0]         pos, ptr_adv;
    logic [LW-1:0]         win_cnt;
    logic                  mm, active, process;
    logic [NW-1:0]         fl_inc, fm_inc, run_inc, sl_inc, sm_inc, split_new;
    logic                  seed_rej, past_min, rate_rej, run_over, win_over, floor_rej;

    assign mm = (word.read_base != word.ref_base);

    // Effective window length and mask
    always_comb
    begin
        wl_ext = CMPW'(cfg.window_length);
        if (wl_ext == '0)
            eff_len = CMPW'(1);
        else if (wl_ext > CMPW'(WINDOW_MAX))
            eff_len = CMPW'(WINDOW_MAX);
        else
            eff_len = wl_ext;
        for (int k = 0; k < WINDOW_MAX; k++)
            win_mask[k] = (CMPW'(k) < eff_len);
    end

    // Start-of-read clear
    always_comb
    begin
        if (word.first_of_read)
        begin
            cur_idx    = '0;
            cur_second = 1'b0;
            cur_rej    = 1'b0;
            cur_fl     = '0;
            cur_fm     = '0;
            cur_run    = '0;
            cur_sl     = '0;
            cur_sm     = '0;
            cur_flags  = '0;
            cur_ptr    = '0;
            cur_split  = '0;
        end
        else
        begin
            cur_idx    = idx_reg;
            cur_second = second_reg;
            cur_rej    = rej_reg;
            cur_fl     = fl_reg;
            cur_fm     = fm_reg;
            cur_run    = run_reg;
            cur_sl     = sl_reg;
            cur_sm     = sm_reg;
            cur_flags  = flags_reg;
            cur_ptr    = ptr_reg;
            cur_split  = split_reg;
        end
    end

    // Counter updates and limit compares
    always_comb
    begin
        active  = (cur_idx < NW'(MAX_READ_LENGTH));
        process = active && !cur_rej;

        pos      = (CMPW'(cur_ptr) < eff_len) ? cur_ptr : '0;
        flags_wr = cur_flags;
        flags_wr[pos] = mm;
        win_cnt  = LW'($countones(flags_wr & win_mask));
        ptr_adv  = ((CMPW'(pos) + CMPW'(1)) >= eff_len) ? '0 : (pos + PW'(1));

        fl_inc  = cur_fl + NW'(1);
        fm_inc  = cur_fm + NW'(mm);
        run_inc = mm ? (cur_run + NW'(1)) : '0;
        sl_inc  = cur_sl + NW'(1);
        sm_inc  = cur_sm + NW'(mm);

        seed_rej = mm && (SW'(fl_inc) < SW'(cfg.seed_length));
        past_min = (SW'(fl_inc) >= SW'(cfg.first_part_min_length));
        rate_rej = ((PRODW'(fm_inc) << RATE_W) >
                    (PRODW'(cfg.first_rate_roof) * PRODW'(fl_inc)));
        run_over = (SW'(run_inc) > SW'(cfg.mismatch_run_limit));
        win_over = ((WPRODW'(win_cnt) << RATE_W) >
                    (WPRODW'(cfg.window_rate_limit) * WPRODW'(eff_len)));
        floor_rej = (SW'(sl_inc) > SW'(cfg.second_part_min_length)) &&
                    ((PRODW'(sm_inc) << RATE_W) <
                     (PRODW'(cfg.second_rate_floor) * PRODW'(sl_inc)));
        // split backs up over the trailing mismatch run
        split_new = cur_idx + NW'(1) - run_inc;
    end

    // Next state
    always_comb
    begin
        idx_next    = active ? (cur_idx + NW'(1)) : cur_idx;
        second_next = cur_second;
        rej_next    = cur_rej;
        fl_next     = cur_fl;
        fm_next     = cur_fm;
        run_next    = cur_run;
        sl_next     = cur_sl;
        sm_next     = cur_sm;
        flags_next  = cur_flags;
        ptr_next    = cur_ptr;
        split_next  = cur_split;

        if (process && !cur_second)
        begin
            fl_next    = fl_inc;
            fm_next    = fm_inc;
            run_next   = run_inc;
            flags_next = flags_wr;
            if (seed_rej || (past_min && rate_rej))
            begin
                rej_next = 1'b1;
            end
            else
            begin
                if (past_min && (run_over || win_over))
                begin
                    second_next = 1'b1;
                    split_next  = split_new;
                    sl_next     = run_inc;
                    sm_next     = run_inc;
                end
                ptr_next = ptr_adv;
            end
        end
        else if (process)
        begin
            sl_next = sl_inc;
            sm_next = sm_inc;
            if (floor_rej)
                rej_next = 1'b1;
        end
    end

    // Verdict after this word
    always_comb
    begin
        result.split_position = '0;
        if (rej_next)
        begin
            result.scan_status = STATUS_REJECTED;
        end
        else if (second_next && (sl_next != '0))
        begin
            result.scan_status    = STATUS_SPLIT;
            result.split_position = SPLIT_W'(split_next);
        end
        else
        begin
            result.scan_status = STATUS_NO_SPLIT;
        end
    end

    // State registers; cleared once the last base has been scored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            second_reg <= 1'b0;
            rej_reg    <= 1'b0;
            fl_reg     <= '0;
            fm_reg     <= '0;
            run_reg    <= '0;
            sl_reg     <= '0;
            sm_reg     <= '0;
            flags_reg  <= '0;
            ptr_reg    <= '0;
            split_reg  <= '0;
        end
        else if (fire)
        begin
            if (word.last_of_read)
            begin
                idx_reg    <= '0;
                second_reg <= 1'b0;
                rej_reg    <= 1'b0;
                fl_reg     <= '0;
                fm_reg     <= '0;
                run_reg    <= '0;
                sl_reg     <= '0;
                sm_reg     <= '0;
                flags_reg  <= '0;
                ptr_reg    <= '0;
                split_reg  <= '0;
            end
            else
            begin
                idx_reg    <= idx_next;
                second_reg <= second_next;
                rej_reg    <= rej_next;
                fl_reg     <= fl_next;
                fm_reg     <= fm_next;
                run_reg    <= run_next;
                sl_reg     <= sl_next;
                sm_reg     <= sm_next;
                flags_reg  <= flags_next;
                ptr_reg    <= ptr_next;
                split_reg  <= split_next;
            end
        end
    end

    // Counter consistency
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && word.last_of_read |=> (idx_reg == '0) && !rej_reg && !second_reg)
        else $error("per-read state not cleared after last base");

    a_second_counts: assert property (@(posedge clk) disable iff (!rst_n)
        sm_reg <= sl_reg)
        else $error("second part mismatches exceed its length");

    a_first_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg <= fm_reg) && (fm_reg <= fl_reg))
        else $error("first part run or mismatch count out of bounds");

    a_no_second_len: assert property (@(posedge clk) disable iff (!rst_n)
        !second_reg |-> (sl_reg == '0) && (sm_reg == '0))
        else $error("second part counters moved before the switch");

endmodule

/* rtl/core/read_splice_point_scanner.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word
// base      in         base_valid/stall     read_base, ref_base, first_of_read, last_of_read
// result    out        result_valid/stall   scan_status, split_position
// config    in         APB psel/penable     eight registers at byte address 4*i
//
// One base word per cycle is taken while base_stall is low; the per-read counters
// in rpss_scan update between the input register and the result register.
// A result is valid after its last base passes the input and then the result register.
// Reset (rst_n low) restores the register defaults and clears all read state.
// base_stall rises only while a last base waits behind a held, stalled result.

module read_splice_point_scanner #(
    parameter int MAX_READ_LENGTH = rpss_pkg::DEF_MAX_READ_LENGTH,
    parameter int WINDOW_MAX      = rpss_pkg::DEF_WINDOW_MAX
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            base_valid,
    output logic                            base_stall,
    input  rpss_pkg::base_word_t            base_word,
    output logic                            result_valid,
    input  logic                            result_stall,
    output rpss_pkg::result_word_t          result_word,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rpss_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rpss_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rpss_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import rpss_pkg::*;

    cfg_t         cfg;
    base_word_t   in_word_reg, in_word_next;
    logic         in_vld_reg, in_vld_next;
    result_word_t out_word_reg, out_word_next;
    logic         out_vld_reg, out_vld_next;
    result_word_t scan_result;
    logic         out_free, advance, accept;

    rpss_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rpss_scan #(
        .MAX_READ_LENGTH (MAX_READ_LENGTH),
        .WINDOW_MAX      (WINDOW_MAX)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (advance),
        .word   (in_word_reg),
        .result (scan_result)
    );

    // Flow control: only a last base needs room in the result register
    assign out_free   = !out_vld_reg || !result_stall;
    assign advance    = in_vld_reg && (!in_word_reg.last_of_read || out_free);
    assign base_stall = in_vld_reg && !advance;
    assign accept     = base_valid && !base_stall;

    assign result_valid = out_vld_reg;
    assign result_word  = out_word_reg;

    // Input and result register next values
    always_comb
    begin
        in_word_next  = in_word_reg;
        in_vld_next   = in_vld_reg;
        out_word_next = out_word_reg;
        out_vld_next  = out_vld_reg;

        if (accept)
        begin
            in_word_next = base_word;
            in_vld_next  = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        if (advance && in_word_reg.last_of_read)
        begin
            out_word_next = scan_result;
            out_vld_next  = 1'b1;
        end
        else if (!result_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_word_reg  <= in_word_next;
        out_word_reg <= out_word_next;
    end

endmodule

/* tb/sv/tb_read_splice_point_scanner.sv */
`timescale 1ns / 1ps

module tb_read_splice_point_scanner;
    import rpss_pkg::*;

    localparam int MAX_BASES    = DEF_MAX_READ_LENGTH;
    localparam int WIN_MAX      = DEF_WINDOW_MAX;
    localparam int STUCK_LIMIT  = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 6;

    localparam cfg_t RESET_CFG = '{
        seed_length:            RST_SEED_LENGTH,
        first_part_min_length:  RST_FIRST_MIN_LENGTH,
        second_part_min_length: RST_SECOND_MIN_LENGTH,
        mismatch_run_limit:     RST_RUN_LIMIT,
        first_rate_roof:        RST_FIRST_RATE_ROOF,
        second_rate_floor:      RST_SECOND_RATE_FLOOR,
        window_length:          RST_WINDOW_LENGTH,
        window_rate_limit:      RST_WINDOW_RATE_LIMIT
    };

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  base_valid   = 1'b0;
    logic                  base_stall;
    base_word_t            base_word    = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_word_t          result_word;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [CFG_DATA_W-1:0] pwdata       = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // stimulus and expected verdicts
    base_word_t   base_queue[$];
    result_word_t verdict_queue[$];
    result_word_t new_verdict;
    result_word_t want;
    int           queued_items  = 0;
    bit           open_read     = 1'b0;
    int           error_count   = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_requests = 0;
    int           hold_served   = 0;
    int           hold_left     = 0;
    int           stuck_cycles  = 0;

    // scanner shadow state
    cfg_t                 cfg_shadow = RESET_CFG;
    logic [LEN_W-1:0]     rd_index   = '0;
    logic                 second_part = 1'b0;
    logic                 rejected   = 1'b0;
    logic [LEN_W-1:0]     first_len  = '0;
    logic [LEN_W-1:0]     first_mm   = '0;
    logic [LEN_W-1:0]     mm_run     = '0;
    logic [LEN_W-1:0]     second_len = '0;
    logic [LEN_W-1:0]     second_mm  = '0;
    logic [WIN_MAX-1:0]   win_flags  = '0;
    logic [3:0]           win_ptr    = '0;
    logic [4:0]           win_count  = '0;
    logic [SPLIT_W-1:0]   split_idx  = '0;

    read_splice_point_scanner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_valid   (base_valid),
        .base_stall   (base_stall),
        .base_word    (base_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    function automatic void clear_read();
        rd_index    = '0;
        second_part = 1'b0;
        rejected    = 1'b0;
        first_len   = '0;
        first_mm    = '0;
        mm_run      = '0;
        second_len  = '0;
        second_mm   = '0;
        win_flags   = '0;
        win_ptr     = '0;
        win_count   = '0;
        split_idx   = '0;
    endfunction

    // Advance the shadow scanner by one base; returns 1 when a verdict is due
    function automatic bit scan_predict(input base_word_t w, output result_word_t r);
        bit          mm;
        int unsigned len;
        int unsigned pos;
        r = '0;
        mm = (w.read_base != w.ref_base);
        if (w.first_of_read)
            clear_read();
        if (rd_index < MAX_BASES)
        begin
            if (!rejected && !second_part)
            begin
                len = (cfg_shadow.window_length == 0) ? 1 :
                      (cfg_shadow.window_length > WIN_MAX) ? WIN_MAX :
                      cfg_shadow.window_length;
                pos = (win_ptr < len) ? win_ptr : 0;
                first_len++;
                if (mm)
                begin
                    mm_run++;
                    first_mm++;
                    win_flags[pos] = 1'b1;
                end
                else
                begin
                    mm_run = '0;
                    win_flags[pos] = 1'b0;
                end
                // a mismatch inside the seed rejects the read
                if (mm && first_len < cfg_shadow.seed_length)
                    rejected = 1'b1;
                else
                begin
                    win_count = '0;
                    for (int k = 0; k < len; k++)
                        win_count += win_flags[k];
                    if (first_len >= cfg_shadow.first_part_min_length &&
                        32'(first_mm) * 32'd256 >
                        32'(cfg_shadow.first_rate_roof) * 32'(first_len))
                        rejected = 1'b1;
                    else
                    begin
                        // switch backs the split up over the trailing run
                        if (first_len >= cfg_shadow.first_part_min_length &&
                            (mm_run > cfg_shadow.mismatch_run_limit ||
                             32'(win_count) * 32'd256 >
                             32'(cfg_shadow.window_rate_limit) * len))
                        begin
                            second_part = 1'b1;
                            split_idx   = SPLIT_W'(rd_index + 11'd1 - mm_run);
                            second_len  = mm_run;
                            second_mm   = mm_run;
                        end
                        win_ptr = 4'((pos + 1 >= len) ? 0 : pos + 1);
                    end
                end
            end
            else if (!rejected)
            begin
                second_len++;
                if (mm)
                    second_mm++;
                if (second_len > cfg_shadow.second_part_min_length &&
                    32'(second_mm) * 32'd256 <
                    32'(cfg_shadow.second_rate_floor) * 32'(second_len))
                    rejected = 1'b1;
            end
            rd_index++;
        end
        if (!w.last_of_read)
            return 1'b0;
        if (rejected)
            r.scan_status = STATUS_REJECTED;
        else if (second_part && second_len > 0)
        begin
            r.scan_status    = STATUS_SPLIT;
            r.split_position = split_idx;
        end
        else
            r.scan_status = STATUS_NO_SPLIT;
        clear_read();
        return 1'b1;
    endfunction

    function automatic void push_base(input logic [7:0] rb, input logic [7:0] gb,
                                      input bit first, input bit last);
        base_word_t w;
        w.read_base     = rb;
        w.ref_base      = gb;
        w.first_of_read = first;
        w.last_of_read  = last;
        base_queue.insert(base_queue.size(), w);
        queued_items++;
        open_read = !last;
    endfunction

    // One read: mismatch percentage p1 before split_at, p2 from there on.
    // A noisy read gets random framing flags.
    function automatic void push_read(input int len, input int split_at,
                                      input int p1, input int p2, input bit noisy);
        logic [7:0] rb;
        logic [7:0] gb;
        bit         mm;
        bit         first;
        bit         last;
        for (int i = 0; i < len; i++)
        begin
            mm = ($urandom_range(99) < ((i < split_at) ? p1 : p2));
            if (noisy)
                mm = $urandom_range(1);
            rb = 8'($urandom_range(255));
            gb = mm ? (rb ^ 8'($urandom_range(1, 255))) : rb;
            first = noisy ? ($urandom_range(7) == 0) : (i == 0);
            last  = noisy ? ($urandom_range(7) == 0) : (i == len - 1);
            push_base(rb, gb, first, last);
        end
    endfunction

    task automatic cfg_write(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SEED_LENGTH:            cfg_shadow.seed_length            = value[10:0];
            REG_FIRST_PART_MIN_LENGTH:  cfg_shadow.first_part_min_length  = value[10:0];
            REG_SECOND_PART_MIN_LENGTH: cfg_shadow.second_part_min_length = value[10:0];
            REG_MISMATCH_RUN_LIMIT:     cfg_shadow.mismatch_run_limit     = value[10:0];
            REG_FIRST_RATE_ROOF:        cfg_shadow.first_rate_roof        = value[7:0];
            REG_SECOND_RATE_FLOOR:      cfg_shadow.second_rate_floor      = value[7:0];
            REG_WINDOW_LENGTH:          cfg_shadow.window_length          = value[4:0];
            REG_WINDOW_RATE_LIMIT:      cfg_shadow.window_rate_limit      = value[7:0];
            default: ;
        endcase
    endtask

    // Write all eight registers; upper data bits sometimes carry junk
    task automatic program_config(input cfg_t c);
        logic [31:0] junk;
        junk = ($urandom_range(3) == 0) ? $urandom() : 32'd0;
        cfg_write(REG_SEED_LENGTH,            {junk[31:11], c.seed_length});
        cfg_write(REG_FIRST_PART_MIN_LENGTH,  {junk[31:11], c.first_part_min_length});
        cfg_write(REG_SECOND_PART_MIN_LENGTH, {junk[31:11], c.second_part_min_length});
        cfg_write(REG_MISMATCH_RUN_LIMIT,     {junk[31:11], c.mismatch_run_limit});
        cfg_write(REG_FIRST_RATE_ROOF,        {junk[31:8], c.first_rate_roof});
        cfg_write(REG_SECOND_RATE_FLOOR,      {junk[31:8], c.second_rate_floor});
        cfg_write(REG_WINDOW_LENGTH,          {junk[31:5], c.window_length});
        cfg_write(REG_WINDOW_RATE_LIMIT,      {junk[31:8], c.window_rate_limit});
    endtask

    // Wait until every base is taken and every verdict has come back
    task automatic drain();
        do
            @(negedge clk);
        while (base_queue.size() != 0 || base_valid || verdict_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_phase(input int target, input bit with_long);
        int start;
        int len;
        int kind;
        if (with_long)
            push_read(MAX_BASES + 6, $urandom_range(990, MAX_BASES - 1), 0, 100, 1'b0);
        start = queued_items;
        while (queued_items - start < target)
        begin
            len  = ($urandom_range(99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 120);
            kind = $urandom_range(99);
            if (kind < 60)
                push_read(len, $urandom_range(len), $urandom_range(10),
                          $urandom_range(40, 100), 1'b0);
            else if (kind < 80)
                push_read(len, len, $urandom_range(100), 0, 1'b0);
            else if (kind < 88)
                push_read(len, len, 0, 0, 1'b0);
            else
                push_read(len, 0, 0, 0, 1'b1);
        end
        // close any read left open so the next setting starts clean
        if (open_read)
            push_base(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    // Base driver: predicts each accepted word, then offers the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (base_valid && !base_stall)
            begin
                if (scan_predict(base_word, new_verdict))
                    verdict_queue.insert(verdict_queue.size(), new_verdict);
            end
            if (!base_valid || !base_stall)
            begin
                if (base_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    base_word  <= base_queue.pop_front();
                    base_valid <= 1'b1;
                end
                else
                    base_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served  <= hold_requests;
            hold_left    <= LONG_HOLD;
            result_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (verdict_queue.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual status %0d split %0d",
                         $time, result_word.scan_status, result_word.split_position);
                error_count++;
            end
            else
            begin
                want = verdict_queue.pop_front();
                if (result_word.scan_status !== want.scan_status)
                begin
                    $display("%0t: scan_status mismatch, expected %0d actual %0d",
                             $time, want.scan_status, result_word.scan_status);
                    error_count++;
                end
                if (result_word.split_position !== want.split_position)
                begin
                    $display("%0t: split_position mismatch, expected %0d actual %0d",
                             $time, want.split_position, result_word.split_position);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((base_valid && !base_stall) || (result_valid && !result_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: timeout, %0d verdicts outstanding", $time, verdict_queue.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        cfg_t c;
        int   burst_start;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed reads under the reset setting
        push_base(8'h00, 8'h00, 1'b1, 1'b1);
        push_base(8'hFF, 8'hFF, 1'b1, 1'b1);
        push_base(8'hFF, 8'h00, 1'b1, 1'b1);
        push_base(8'h00, 8'hFF, 1'b1, 1'b1);
        // seed mismatch, later bases ignored
        push_base(8'h41, 8'h54, 1'b1, 1'b0);
        push_base(8'h43, 8'h43, 1'b0, 1'b0);
        push_base(8'h47, 8'h47, 1'b0, 1'b1);
        // clean prefix then a mismatch on the last base: split at 3
        push_base(8'h41, 8'h41, 1'b1, 1'b0);
        push_base(8'h43, 8'h43, 1'b0, 1'b0);
        push_base(8'h47, 8'h47, 1'b0, 1'b0);
        push_base(8'h54, 8'h41, 1'b0, 1'b1);
        // second part too clean: rejected by the floor
        push_base(8'h41, 8'h41, 1'b1, 1'b0);
        push_base(8'h43, 8'h43, 1'b0, 1'b0);
        push_base(8'h47, 8'h47, 1'b0, 1'b0);
        push_base(8'h54, 8'h41, 1'b0, 1'b0);
        for (int i = 0; i < 5; i++)
            push_base(8'h47, 8'h47, 1'b0, i == 4);
        drain();

        // switch on a matching base leaves an empty second part
        c = RESET_CFG;
        c.seed_length           = '0;
        c.first_part_min_length = 11'd2;
        program_config(c);
        push_base(8'h41, 8'h43, 1'b1, 1'b0);
        push_base(8'h47, 8'h47, 1'b0, 1'b1);
        drain();

        for (int p = 0; p < 9; p++)
        begin
            case (p)
                0: c = '0;
                1: c = '{11'd1024, 11'd1024, 11'd1024, 11'd1024, 8'd255, 8'd255, 5'd16, 8'd255};
                2: c = RESET_CFG;
                8: c = '1;
                default:
                begin
                    c.seed_length            = 11'($urandom_range(8));
                    c.first_part_min_length  = 11'($urandom_range(12));
                    c.second_part_min_length = 11'($urandom_range(12));
                    c.mismatch_run_limit     = 11'($urandom_range(6));
                    c.first_rate_roof        = 8'($urandom_range(255));
                    c.second_rate_floor      = 8'($urandom_range(255));
                    c.window_length          = ($urandom_range(9) == 0) ?
                                               5'($urandom_range(31)) :
                                               5'($urandom_range(1, 16));
                    c.window_rate_limit      = 8'($urandom_range(255));
                end
            endcase
            program_config(c);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            run_random_phase(70, p == 3);
            drain();
        end

        // back-pressure: short reads against a long receiver hold-off
        program_config(RESET_CFG);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        burst_start    = queued_items;
        while (queued_items - burst_start < 150)
            push_read($urandom_range(1, 3), 3, 0, 100, 1'b0);
        hold_requests++;
        drain();

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
